>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the GELU backward block.
// Depends on nothing; users provide clk and arst_n in their scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge, off while in reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Plain invariant checked at every rising clock edge, off while in reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

>>> hw/rtl/geb_pkg.sv
// Types and constants of the GELU backward pipeline.
// No dependencies; used by gelu_exact_backward.
package geb_pkg;

	localparam int DW = 16;
	localparam int FB = 12;
	localparam int NST = 47;

	// Q28 internal format
	localparam logic [28:0] QONE = 29'h1000_0000;
	localparam logic [27:0] C_LN2 = 28'd186065280;
	localparam logic [25:0] C_P = 26'd62180899;
	localparam logic [26:0] C_BETA = 27'd107090253;
	localparam logic [15:0] SPAN_LIM = 16'(6 << FB);
	localparam int N_MAX = 25;

	// cdf polynomial coefficients b1..b5 in Q28
	localparam logic signed [31:0] CDF_C [5] = '{
		32'sd85733327, -32'sd95714361, 32'sd478211842, -32'sd488889679, 32'sd357092823
	};

	// reciprocal multipliers for exact floor(v / k), v < 2^28
	localparam logic [28:0] RCP_M [10] = '{
		29'd0,
		29'(((64'd1 << 28) + 64'd0) / 64'd1),
		29'(((64'd1 << 29) + 64'd1) / 64'd2),
		29'(((64'd1 << 30) + 64'd2) / 64'd3),
		29'(((64'd1 << 30) + 64'd3) / 64'd4),
		29'(((64'd1 << 31) + 64'd4) / 64'd5),
		29'(((64'd1 << 31) + 64'd5) / 64'd6),
		29'(((64'd1 << 31) + 64'd6) / 64'd7),
		29'(((64'd1 << 31) + 64'd7) / 64'd8),
		29'(((64'd1 << 32) + 64'd8) / 64'd9)
	};
	localparam int unsigned RCP_SH [10] = '{0, 28, 29, 30, 30, 31, 31, 31, 31, 32};

	// one pipeline item with all its working fields
	typedef struct packed {
		logic signed [15:0] grad;
		logic signed [15:0] xv;
		logic               neg;
		logic               span;
		logic [15:0]        ax;
		logic [30:0]        sq;
		logic [33:0]        u;
		logic [24:0]        thm;
		logic [4:0]         n;
		logic [29:0]        den;
		logic [27:0]        r;
		logic [28:0]        p;
		logic [27:0]        v;
		logic [30:0]        rem;
		logic [28:0]        t;
		logic [28:0]        e;
		logic [26:0]        phi;
		logic signed [63:0] mp;
		logic signed [31:0] q;
		logic signed [33:0] diff;
		logic signed [61:0] pd;
		logic signed [31:0] d;
		logic signed [47:0] gp;
		logic signed [15:0] res;
	} pipe_t;

endpackage

>>> hw/rtl/gelu_exact_backward.sv
// Throughput: one item per cycle while the output is not held; the 29-stage
// reciprocal divider followed by the 10-stage cdf polynomial sets the depth, not the rate.
// The whole pipe advances when the output register is empty or taken.
// Reset (arst_n low, asynchronous) clears the valid bits only.
// Uses geb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gelu_exact_backward (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [15:0] grad, [31:16] x_value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // [15:0] grad_in
);

	localparam int NST = geb_pkg::NST;

	// signed truncation toward zero of x / 2^28
	function automatic logic signed [63:0] tdiv(input logic signed [63:0] x);
		tdiv = (x + (x[63] ? 64'sd268435455 : 64'sd0)) >>> 28;
	endfunction

	// work done by pipeline stage s
	function automatic geb_pkg::pipe_t stage_fn(input int unsigned s, input geb_pkg::pipe_t d);
		geb_pkg::pipe_t o;
		logic [15:0] xr;
		logic [31:0] sq32;
		logic [41:0] pa;
		logic [24:0] oh;
		logic [33:0] sub;
		logic [30:0] rsh;
		logic [56:0] hp;
		logic [56:0] hq;
		logic [55:0] he;
		logic signed [63:0] dd;
		logic [47:0] mag;
		logic [20:0] rnd;
		int unsigned j;
		int unsigned k;
		int unsigned b;
		int unsigned ci;
		o = d;
		xr = d.xv;
		// magnitude, sign, span test, square
		if (s == 1) begin
			o.neg = xr[15];
			o.ax = xr[15] ? (~xr + 16'd1) : xr;
			o.span = (o.ax >= geb_pkg::SPAN_LIM);
			sq32 = {16'd0, o.ax} * {16'd0, o.ax};
			o.sq = sq32[30:0];
		end
		// u = x^2/2 in Q28, ln2 thresholds, divisor of t
		if (s == 2) begin
			o.u = {d.sq, 3'b000};
			for (k = 1; k <= geb_pkg::N_MAX; k++) begin
				o.thm[k-1] = (o.u >= 34'(k) * 34'(geb_pkg::C_LN2));
			end
			pa = {16'd0, geb_pkg::C_P} * {26'd0, d.ax};
			o.den = 30'(geb_pkg::QONE) + 30'(pa >> 12);
			o.rem = 31'(1 << 27);
			o.t = '0;
			o.p = geb_pkg::QONE;
		end
		// n = floor(u / ln2), remainder r
		if (s == 3) begin
			o.n = 5'($countones(d.thm));
			oh = d.thm & ~(d.thm >> 1);
			sub = '0;
			for (k = 1; k <= geb_pkg::N_MAX; k++) begin
				sub = sub | (oh[k-1] ? 34'(k) * 34'(geb_pkg::C_LN2) : 34'd0);
			end
			o.r = 28'(d.u - sub);
		end
		// restoring divider, one quotient bit per stage
		if (s >= 3 && s <= 31) begin
			b = 31 - s;
			rsh = {d.rem[29:0], 1'b0};
			if (rsh >= {1'b0, d.den}) begin
				o.rem = rsh - {1'b0, d.den};
				o.t[b] = 1'b1;
			end else begin
				o.rem = rsh;
			end
		end
		// exp(-r) Horner steps k = 9..2: multiply, then divide by k
		if (s >= 4 && s <= 19) begin
			j = s - 4;
			k = 9 - (j >> 1);
			if (j[0] == 1'b0) begin
				hp = {29'd0, d.r} * {28'd0, d.p};
				o.v = hp[55:28];
			end else begin
				hq = {29'd0, d.v} * {28'd0, geb_pkg::RCP_M[k]};
				o.p = geb_pkg::QONE - 29'(hq >> geb_pkg::RCP_SH[k]);
			end
		end
		// last Horner step, k = 1
		if (s == 20) begin
			hp = {29'd0, d.r} * {28'd0, d.p};
			o.p = geb_pkg::QONE - 29'(hp[55:28]);
		end
		if (s == 21) begin
			o.e = d.p >> d.n;
		end
		// pdf
		if (s == 22) begin
			he = {27'd0, d.e} * {29'd0, geb_pkg::C_BETA};
			o.phi = he[54:28];
		end
		// cdf polynomial in t: multiply stages
		if (s == 32) begin
			o.mp = geb_pkg::CDF_C[4] * $signed({1'b0, d.t});
		end
		if (s == 34 || s == 36 || s == 38 || s == 40) begin
			o.mp = d.q * $signed({1'b0, d.t});
		end
		// cdf polynomial: scale and add next coefficient
		if (s == 33 || s == 35 || s == 37 || s == 39) begin
			ci = (39 - s) >> 1;
			o.q = geb_pkg::CDF_C[ci] + 32'(tdiv(d.mp));
		end
		if (s == 41) begin
			o.q = 32'(tdiv(d.mp));
		end
		if (s == 42) begin
			o.diff = $signed({2'b00, d.ax, 16'd0}) - 34'(d.q);
		end
		if (s == 43) begin
			o.pd = $signed({1'b0, d.phi}) * d.diff;
		end
		// derivative for |x|, clamped beyond the span
		if (s == 44) begin
			dd = 64'sd268435456 + tdiv(64'(d.pd));
			o.d = d.span ? 32'sd268435456 : 32'(dd);
		end
		// mirror for negative x
		if (s == 45) begin
			o.d = d.neg ? (32'sd268435456 - d.d) : d.d;
		end
		if (s == 46) begin
			o.gp = d.grad * d.d;
		end
		// round half away from zero, saturate
		if (s == 47) begin
			mag = d.gp[47] ? 48'(-d.gp) : 48'(d.gp);
			rnd = 21'((mag + 48'h800_0000) >> 28);
			if (!d.gp[47]) begin
				o.res = (rnd > 21'd32767) ? 16'sd32767 : $signed(rnd[15:0]);
			end else begin
				o.res = (rnd > 21'd32768) ? -16'sd32768 : -$signed(rnd[15:0]);
			end
		end
		stage_fn = o;
	endfunction

	geb_pkg::pipe_t in_item;
	geb_pkg::pipe_t nxt    [1:NST];
	geb_pkg::pipe_t pipe_s [1:NST];
	logic [NST:1]   vld_s;
	logic           en;

	// whole pipe moves unless the output item is held
	assign en = !vld_s[NST] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_s[NST];
	assign m_axis_tdata = pipe_s[NST].res;

	always_comb begin
		in_item = '0;
		in_item.grad = $signed(s_axis_tdata[15:0]);
		in_item.xv = $signed(s_axis_tdata[31:16]);
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NST-1:1], s_axis_tvalid};
		end
	end

	// payload stages
	for (genvar gs = 1; gs <= NST; gs++) begin : g_stage
		if (gs == 1) begin : g_first
			assign nxt[gs] = stage_fn(gs, in_item);
		end else begin : g_next
			assign nxt[gs] = stage_fn(gs, pipe_s[gs-1]);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				pipe_s[gs] <= nxt[gs];
			end
		end
	end

	`ASSERT_IMPL(a_div_rem, vld_s[31], pipe_s[31].rem < 31'(pipe_s[31].den), "divider remainder not below divisor")
	`ASSERT_IMPL(a_recip_rng, vld_s[31], pipe_s[31].t != '0 && pipe_s[31].t <= geb_pkg::QONE, "reciprocal t out of range")
	`ASSERT_IMPL(a_exp_rng, vld_s[20], pipe_s[20].p != '0 && pipe_s[20].p <= geb_pkg::QONE, "exp series out of range")
	`ASSERT_IMPL(a_span_clamp, vld_s[45] && pipe_s[45].span, pipe_s[45].d == (pipe_s[45].neg ? 32'sd0 : 32'sd268435456), "clamped derivative wrong")

endmodule

>>> sim/gelu_grad_checker.sv
// Watches both stream ports of gelu_exact_backward, predicts grad_in for every
// accepted item, and compares the results in order. Depends on nothing else.
module gelu_grad_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [15:0] grad, [31:16] x_value
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,  // [15:0] grad_in
	output int          fail_count,
	output int          pending
);

	localparam int QB = 28;
	localparam longint unsigned Q_ONE = 64'd1 << QB;
	localparam longint unsigned LN2_Q = 64'd186065280;
	localparam longint unsigned P_Q = 64'd62180899;
	localparam longint unsigned BETA_Q = 64'd107090253;
	localparam longint CDF_B [5] = '{
		64'sd85733327, -64'sd95714361, 64'sd478211842, -64'sd488889679, 64'sd357092823
	};

	logic signed [15:0] grad_in_q [$];

	// exp(-u) in Q28: range reduction by ln2, then a Taylor series in Horner form
	function automatic longint unsigned exp_neg_q28(longint unsigned u);
		longint unsigned n, r, p;
		n = u / LN2_Q;
		r = u - n * LN2_Q;
		p = Q_ONE;
		for (int k = 9; k >= 1; k--)
			p = Q_ONE - ((r * p) >> QB) / longint'(k);
		if (n >= 63)
			return 0;
		return p >> n;
	endfunction

	// GELU derivative for a = |x| in Q28, a below the clamp span
	function automatic longint dgelu_pos_q28(longint unsigned a);
		longint unsigned e, den;
		longint phi, t, q;
		e = exp_neg_q28((a * a) >> (QB + 1));
		phi = longint'((e * BETA_Q) >> QB);
		den = Q_ONE + ((P_Q * a) >> QB);
		t = longint'((Q_ONE * Q_ONE) / den);
		q = CDF_B[4];
		for (int k = 3; k >= 0; k--)
			q = CDF_B[k] + (q * t) / longint'(Q_ONE);
		q = (q * t) / longint'(Q_ONE);
		return longint'(Q_ONE) + (phi * (longint'(a) - q)) / longint'(Q_ONE);
	endfunction

	// grad * D(x), rounded half away from zero, saturated to 16 bits
	function automatic logic signed [15:0] grad_times_dgelu(logic signed [15:0] g,
		logic signed [15:0] x);
		longint gv, xv, d, prod;
		longint unsigned ax, mag;
		gv = g;
		xv = x;
		ax = (xv < 0) ? longint'(-xv) : longint'(xv);
		if (ax >= (64'd6 << 12))
			d = Q_ONE;
		else
			d = dgelu_pos_q28(ax << (QB - 12));
		if (xv < 0)
			d = longint'(Q_ONE) - d;
		prod = gv * d;
		mag = (prod < 0) ? longint'(-prod) : longint'(prod);
		mag = (mag + (64'd1 << (QB - 1))) >> QB;
		if (prod < 0) begin
			if (mag > 32768)
				return -16'sd32768;
			return -16'(mag);
		end
		if (mag > 32767)
			return 16'sd32767;
		return 16'(mag);
	endfunction

	task automatic report(string what);
		$display("mismatch @%0t: %s", $realtime, what);
		fail_count++;
	endtask

	initial fail_count = 0;

	// push predictions for accepted inputs, compare accepted results
	always @(posedge clk) begin
		logic signed [15:0] want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				grad_in_q.push_back(grad_times_dgelu(s_axis_tdata[15:0], s_axis_tdata[31:16]));
			if (m_axis_tvalid && m_axis_tready) begin
				if (grad_in_q.size() == 0)
					report($sformatf("unexpected grad_in %h", m_axis_tdata));
				else begin
					want = grad_in_q.pop_front();
					if (m_axis_tdata !== want)
						report($sformatf("grad_in got %h want %h", m_axis_tdata, want));
				end
			end
		end
		pending = grad_in_q.size();
	end

endmodule

>>> sim/tb.sv
// Testbench top for gelu_exact_backward: clock, reset, stimulus and verdict.
// Depends on gelu_grad_checker and the block's RTL.
module tb;

	localparam int LATENCY = 47;
	localparam int STALL_LIMIT = 5000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;  // [15:0] grad, [31:16] x_value
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [15:0] m_axis_tdata;       // [15:0] grad_in
	int          fail_count, pending, stall_cycles;
	bit          quiet = 0;

	always #5 clk = ~clk;

	gelu_exact_backward i_dut (.*);

	gelu_grad_checker i_chk (.*);

	// output backpressure
	always @(negedge clk)
		m_axis_tready <= quiet || ($urandom_range(0, 99) >= 15);

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles = 0;
		else if (arst_n) begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// offer one item with random gaps, return at the falling edge after acceptance
	task automatic send_item(logic signed [15:0] g, logic signed [15:0] x);
		while (!quiet && $urandom_range(0, 99) < 15) begin
			s_axis_tvalid <= 0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {x, g};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] pick_x();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 70)
			return 16'($signed($urandom_range(0, 53248)) - 26624);
		if (sel < 80)
			return 16'(($urandom_range(0, 1) ? 24576 : -24576) + $signed($urandom_range(0, 16)) - 8);
		return 16'($urandom);
	endfunction

	initial begin
		logic signed [15:0] edge_vals [8];
		edge_vals = '{16'sd0, 16'sd32767, -16'sd32768, 16'sd4096, -16'sd4096,
			16'sd1, -16'sd1, 16'sd24575};
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: field extremes, clamp boundary at |x| = 6.0, unit values
		foreach (edge_vals[i])
			send_item(edge_vals[i], 16'sd4096);
		send_item(16'sd32767, 16'sd24575);
		send_item(16'sd32767, 16'sd24576);
		send_item(16'sd32767, -16'sd24575);
		send_item(-16'sd32768, -16'sd24576);
		send_item(-16'sd32768, 16'sd32767);
		send_item(16'sd32767, -16'sd32768);
		send_item(-16'sd32768, 16'sd0);
		send_item(16'sd32767, 16'sd0);
		send_item(16'sd4096, -16'sd1);
		send_item(16'sd4096, 16'sd1);
		send_item(16'sd4096, -16'sd3000);
		send_item(-16'sd32768, 16'sd2600);
		send_item(16'sd12345, -16'sd12000);
		send_item(-16'sd777, 16'sd20000);
		send_item(16'sd4096, 16'sd8192);

		// random: mostly in-span x, full-range grad, one stretch with no gaps
		for (int i = 0; i < 1330; i++) begin
			quiet = (i >= 300 && i < 600);
			send_item($urandom_range(0, 99) < 60 ? 16'($urandom)
				: 16'($signed($urandom_range(0, 8192)) - 4096), pick_x());
		end
		quiet = 0;
		s_axis_tvalid <= 0;

		while (pending != 0)
			@(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/geb_pkg.sv
hw/rtl/gelu_exact_backward.sv
sim/gelu_grad_checker.sv
sim/tb.sv
